FILE: sv/dsf_pkg.sv
package dsf_pkg;

   localparam int ACCUM_W = 30;
   localparam int DCNT_W  = 4;
   localparam int CCNT_W  = 2;

   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_NINE  = 8'h39;
   localparam logic [7:0] CHAR_PLUS  = 8'h2b;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] CHAR_POINT = 8'h2e;

   localparam logic [2:0] ERR_NONE       = 3'd0;
   localparam logic [2:0] ERR_EMPTY      = 3'd1;
   localparam logic [2:0] ERR_ONLY_SIGN  = 3'd2;
   localparam logic [2:0] ERR_ONLY_POINT = 3'd3;
   localparam logic [2:0] ERR_SIGN_POINT = 3'd4;
   localparam logic [2:0] ERR_BAD_INT    = 3'd5;
   localparam logic [2:0] ERR_BAD_FRAC   = 3'd6;
   localparam logic [2:0] ERR_TOO_MANY   = 3'd7;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
      logic       empty_string;
   } req_type;

   typedef struct packed {
      logic signed [63:0] value_q;
      logic [2:0]         error_code;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_MERGE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic start;
      logic done;
   } div_ctrl_type;

   function automatic logic [ACCUM_W-1:0] pow10(input logic [DCNT_W-1:0] n);
      logic [ACCUM_W-1:0] p;
      case (n)
         4'd1:    p = ACCUM_W'(10);
         4'd2:    p = ACCUM_W'(100);
         4'd3:    p = ACCUM_W'(1000);
         4'd4:    p = ACCUM_W'(10000);
         4'd5:    p = ACCUM_W'(100000);
         4'd6:    p = ACCUM_W'(1000000);
         4'd7:    p = ACCUM_W'(10000000);
         4'd8:    p = ACCUM_W'(100000000);
         4'd9:    p = ACCUM_W'(1000000000);
         default: p = ACCUM_W'(1);
      endcase
      return p;
   endfunction

endpackage

FILE: sv/dsf_divider.sv
module dsf_divider #(
   parameter int FRAC_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dsf_pkg::div_ctrl_type         ctrl_in,
   output dsf_pkg::div_ctrl_type         ctrl_out,
   input  logic [dsf_pkg::ACCUM_W-1:0]   numer,
   input  logic [dsf_pkg::ACCUM_W-1:0]   denom,
   output logic [FRAC_BITS:0]            quotient
);
   import dsf_pkg::*;

   localparam int CW = $clog2(FRAC_BITS + 1);

   logic [ACCUM_W-1:0] rem_ff, rem_in;
   logic [ACCUM_W-1:0] den_ff, den_in;
   logic [FRAC_BITS:0] quo_ff, quo_in;
   logic [CW-1:0]      cnt_ff, cnt_in;
   logic               run_ff, run_in;
   logic               rnd_ff, rnd_in;
   logic               done_ff, done_in;

   logic [ACCUM_W:0]   rem_shift;
   logic [ACCUM_W:0]   rem_half;
   logic               fits;

   always_comb begin
      rem_shift = {rem_ff, 1'b0};
      rem_half  = {1'b0, rem_ff} + {2'b00, den_ff[ACCUM_W-1:1]};
      fits      = rem_shift >= {1'b0, den_ff};
      rem_in    = rem_ff;
      den_in    = den_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      run_in    = run_ff;
      rnd_in    = 1'b0;
      done_in   = 1'b0;
      if (ctrl_in.start) begin
         rem_in = numer;
         den_in = denom;
         quo_in = '0;
         cnt_in = CW'(FRAC_BITS);
         run_in = 1'b1;
      end else if (run_ff) begin
         // one quotient bit per cycle, restoring
         if (fits) begin
            rem_in = ACCUM_W'(rem_shift - {1'b0, den_ff});
         end else begin
            rem_in = rem_shift[ACCUM_W-1:0];
         end
         quo_in = {quo_ff[FRAC_BITS-1:0], fits};
         cnt_in = cnt_ff - CW'(1);
         if (cnt_ff == CW'(1)) begin
            run_in = 1'b0;
            rnd_in = 1'b1;
         end
      end else if (rnd_ff) begin
         // round to nearest, ties up
         quo_in  = quo_ff + (FRAC_BITS+1)'(rem_half >= {1'b0, den_ff});
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         rnd_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         rnd_ff  <= rnd_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   always_comb begin
      ctrl_out.start = run_ff;
      ctrl_out.done  = done_ff;
   end

   assign quotient = quo_ff;

endmodule

FILE: sv/decimal_string_to_fixed.sv
// decimal string to signed fixed-point converter
//
// req channel: one character per transaction (req_data.char_code), with
// req_data.last_char marking the end of the string; a transaction with
// req_data.empty_string set stands for a zero-length string and ends it.
// rsp channel: one transaction per ended string, rsp_data.value_q with
// FRAC_BITS fractional bits and rsp_data.error_code (value is 0 on error).
// non-final characters give no response. a string end starts the restoring
// divider that forms the rounded fraction one quotient bit at a time and
// then rounds it; ST_MERGE next adds the integer part, and ST_FINISH applies
// the sign as it loads the response into the output register. req_ready is
// low from the final character until the response is loaded into the output
// register. the output register lets the next string start while a response
// waits; if rsp_ready is held low the block waits before loading the
// following response. reset clears all parse state and drops rsp_valid.
module decimal_string_to_fixed #(
   parameter int MAX_DIGITS = 9,
   parameter int FRAC_BITS  = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dsf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dsf_pkg::rsp_type rsp_data
);
   import dsf_pkg::*;

   state_type state_ff, state_in;

   logic [CCNT_W-1:0]  ccnt_ff, ccnt_in;
   logic               neg_ff, neg_in;
   logic               sign_ff, sign_in;
   logic               point_ff, point_in;
   logic [ACCUM_W-1:0] int_ff, int_in;
   logic [ACCUM_W-1:0] frac_ff, frac_in;
   logic [DCNT_W-1:0]  icnt_ff, icnt_in;
   logic [DCNT_W-1:0]  fcnt_ff, fcnt_in;
   logic [2:0]         ferr_ff, ferr_in;
   logic [2:0]         err_ff, err_in;
   logic [63:0]        mag_ff, mag_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   div_ctrl_type       div_req;
   div_ctrl_type       div_sts;
   logic [FRAC_BITS:0] quotient;

   logic               accept;
   logic               rsp_free;
   logic [7:0]         c;
   logic [3:0]         digit;
   logic               is_digit;
   logic [2:0]         final_err;

   localparam logic [DCNT_W-1:0] DMAX = DCNT_W'(MAX_DIGITS);

   assign accept   = req_valid && (state_ff == ST_IDLE);
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign c        = req_data.char_code;
   assign digit    = 4'(c - CHAR_ZERO);
   assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);

   always_comb begin
      state_in     = state_ff;
      ccnt_in      = ccnt_ff;
      neg_in       = neg_ff;
      sign_in      = sign_ff;
      point_in     = point_ff;
      int_in       = int_ff;
      frac_in      = frac_ff;
      icnt_in      = icnt_ff;
      fcnt_in      = fcnt_ff;
      ferr_in      = ferr_ff;
      err_in       = err_ff;
      mag_in       = mag_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      div_req      = '0;
      final_err    = ERR_NONE;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_data.empty_string) begin
                  ccnt_in  = '0;
                  neg_in   = 1'b0;
                  sign_in  = 1'b0;
                  point_in = 1'b0;
                  int_in   = '0;
                  frac_in  = '0;
                  icnt_in  = '0;
                  fcnt_in  = '0;
                  ferr_in  = ERR_NONE;
               end else begin
                  if (ccnt_ff == '0 && (c == CHAR_PLUS || c == CHAR_MINUS)) begin
                     sign_in = 1'b1;
                     neg_in  = (c == CHAR_MINUS);
                  end else if (!point_ff && c == CHAR_POINT) begin
                     point_in = 1'b1;
                  end else if (is_digit) begin
                     if (!point_ff) begin
                        if (icnt_ff < DMAX) begin
                           int_in  = ACCUM_W'(int_ff * ACCUM_W'(10)) + ACCUM_W'(digit);
                           icnt_in = icnt_ff + DCNT_W'(1);
                        end else begin
                           icnt_in = DMAX + DCNT_W'(1);
                           if (ferr_ff == ERR_NONE) ferr_in = ERR_TOO_MANY;
                        end
                     end else begin
                        if (fcnt_ff < DMAX) begin
                           frac_in = ACCUM_W'(frac_ff * ACCUM_W'(10)) + ACCUM_W'(digit);
                           fcnt_in = fcnt_ff + DCNT_W'(1);
                        end else begin
                           fcnt_in = DMAX + DCNT_W'(1);
                           if (ferr_ff == ERR_NONE) ferr_in = ERR_TOO_MANY;
                        end
                     end
                  end else if (!point_ff) begin
                     if (ferr_ff == ERR_NONE || ferr_ff == ERR_TOO_MANY) ferr_in = ERR_BAD_INT;
                  end else begin
                     if (ferr_ff == ERR_NONE ||
                         (ferr_ff == ERR_TOO_MANY && icnt_ff <= DMAX)) ferr_in = ERR_BAD_FRAC;
                  end
                  ccnt_in = (ccnt_ff == CCNT_W'(3)) ? ccnt_ff : ccnt_ff + CCNT_W'(1);
               end

               if (req_data.empty_string) begin
                  final_err = ERR_EMPTY;
               end else if (ccnt_in == CCNT_W'(1) && sign_in) begin
                  final_err = ERR_ONLY_SIGN;
               end else if (ccnt_in == CCNT_W'(1) && point_in) begin
                  final_err = ERR_ONLY_POINT;
               end else if (ccnt_in == CCNT_W'(2) && sign_in && point_in) begin
                  final_err = ERR_SIGN_POINT;
               end else begin
                  final_err = ferr_in;
               end

               if (req_data.last_char || req_data.empty_string) begin
                  err_in        = final_err;
                  div_req.start = 1'b1;
                  state_in      = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            if (div_sts.done) state_in = ST_MERGE;
         end
         ST_MERGE: begin
            mag_in   = (64'(int_ff) << FRAC_BITS) + 64'(quotient);
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_in.error_code = err_ff;
               if (err_ff != ERR_NONE) begin
                  rsp_in.value_q = '0;
               end else if (neg_ff) begin
                  rsp_in.value_q = $signed(~mag_ff + 64'd1);
               end else begin
                  rsp_in.value_q = $signed(mag_ff);
               end
               ccnt_in  = '0;
               neg_in   = 1'b0;
               sign_in  = 1'b0;
               point_in = 1'b0;
               int_in   = '0;
               frac_in  = '0;
               icnt_in  = '0;
               fcnt_in  = '0;
               ferr_in  = ERR_NONE;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ccnt_ff      <= '0;
         neg_ff       <= 1'b0;
         sign_ff      <= 1'b0;
         point_ff     <= 1'b0;
         int_ff       <= '0;
         frac_ff      <= '0;
         icnt_ff      <= '0;
         fcnt_ff      <= '0;
         ferr_ff      <= ERR_NONE;
         err_ff       <= ERR_NONE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ccnt_ff      <= ccnt_in;
         neg_ff       <= neg_in;
         sign_ff      <= sign_in;
         point_ff     <= point_in;
         int_ff       <= int_in;
         frac_ff      <= frac_in;
         icnt_ff      <= icnt_in;
         fcnt_ff      <= fcnt_in;
         ferr_ff      <= ferr_in;
         err_ff       <= err_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      mag_ff <= mag_in;
      rsp_ff <= rsp_in;
   end

   dsf_divider #(
      .FRAC_BITS (FRAC_BITS)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .ctrl_in  (div_req),
      .ctrl_out (div_sts),
      .numer    (frac_in),
      .denom    (pow10(fcnt_in)),
      .quotient (quotient)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
